FILE: hw/rtl/days_between_dates_unit_assert.svh
// assertion macros for the date-difference pipeline
// each check is sampled at the rising clock edge and is off while reset is low
`ifndef DAYS_BETWEEN_DATES_UNIT_ASSERT_SVH
`define DAYS_BETWEEN_DATES_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// plain property under reset
`define DBD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define DBD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define DBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define DBD_ASSERT(lbl, clk, rst_n, prop, msg)
`define DBD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/dbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dbd_pkg;

  localparam int DayW   = 5;
  localparam int MonW   = 4;
  localparam int YearW  = 14;
  localparam int CntW   = 22;
  localparam int StatW  = 2;
  localparam int NumStages = 4;

  typedef enum logic [StatW-1:0] {
    STAT_OK      = 2'd0,
    STAT_ORDER   = 2'd1,
    STAT_INVALID = 2'd2
  } status_t;

  // per-stage load enables and valid bits
  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } pipe_ctl_t;

  // length of a month, 0 for a month code outside 1..12
  function automatic logic [DayW-1:0] month_days(input logic [MonW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the months before month m of a common year
  function automatic logic [8:0] days_before(input logic [MonW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dbd_pipe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dbd_pipe_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic            out_tready,
  output dbd_pkg::pipe_ctl_t   ctl
);
  import dbd_pkg::*;

  logic [NumStages-1:0] vld_r;
  logic [NumStages-1:0] vld_nxt;
  logic [NumStages-1:0] rdy;
  logic [NumStages-1:0] up_vld;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    rdy[NumStages-1] = !vld_r[NumStages-1] || out_tready;
    for (int s = NumStages - 2; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
    up_vld = {vld_r[NumStages-2:0], in_tvalid};
    for (int s = 0; s < NumStages; s++) begin
      vld_nxt[s] = rdy[s] ? up_vld[s] : vld_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = rdy[0];
  assign ctl.en    = rdy;
  assign ctl.vld   = vld_r;

endmodule

`default_nettype wire

FILE: hw/rtl/dbd_date_conv.sv
`timescale 1ns / 1ps
`default_nettype none

module dbd_date_conv (
  input  wire logic                        clk,
  input  wire dbd_pkg::pipe_ctl_t          ctl,
  input  wire logic [dbd_pkg::DayW-1:0]    day,
  input  wire logic [dbd_pkg::MonW-1:0]    month,
  input  wire logic [dbd_pkg::YearW-1:0]   year,
  output logic [dbd_pkg::CntW-1:0]         day_num,
  output logic                             date_ok
);
  import dbd_pkg::*;

  localparam int QW = YearW - 2;
  localparam int RW = 13;
  localparam int PW = QW + RW;
  localparam int HW = 8;
  localparam logic [RW-1:0]   Recip25  = 13'd5243;   // 2^17 / 25, rounded up
  localparam logic [CntW-1:0] YearDays = CntW'(365);
  localparam logic [14:0]     Century  = 15'd100;

  // stage 1: reciprocal multiplies for the century counts
  logic [PW-1:0]    yprod;
  logic [PW-1:0]    pprod;
  logic [YearW-1:0] pyr;

  logic [DayW-1:0]  d1_r;
  logic [MonW-1:0]  m1_r;
  logic [YearW-1:0] y1_r;
  logic [YearW-1:0] p1_r;
  logic [HW-1:0]    yc1_r;
  logic [HW-1:0]    pc1_r;
  logic             rng1_r;

  assign pyr   = year - YearW'(1);
  assign yprod = PW'(year[YearW-1:2]) * PW'(Recip25);
  assign pprod = PW'(pyr[YearW-1:2]) * PW'(Recip25);

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      d1_r   <= day;
      m1_r   <= month;
      y1_r   <= year;
      p1_r   <= pyr;
      yc1_r  <= yprod[PW-1:PW-HW];
      pc1_r  <= pprod[PW-1:PW-HW];
      rng1_r <= (year >= YearW'(1)) && (year <= YearW'(9999));
    end
  end

  // stage 2: leap year, validity and days before the year
  logic            leap2;
  logic [DayW-1:0] mlen2;
  logic [CntW-1:0] ybase2;

  always_comb begin
    leap2 = (y1_r[1:0] == 2'b00) &&
            ((15'(y1_r) != 15'(yc1_r) * Century) || (yc1_r[1:0] == 2'b00));
    mlen2 = month_days(m1_r, leap2);
    ybase2 = YearDays * CntW'(p1_r) + CntW'(p1_r >> 2) - CntW'(pc1_r)
           + CntW'(pc1_r >> 2);
  end

  logic [DayW-1:0] d2_r;
  logic [MonW-1:0] m2_r;
  logic            leap2_r;
  logic            ok2_r;
  logic [CntW-1:0] yb2_r;

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      d2_r    <= d1_r;
      m2_r    <= m1_r;
      leap2_r <= leap2;
      ok2_r   <= rng1_r && (d1_r != '0) && (d1_r <= mlen2);
      yb2_r   <= ybase2;
    end
  end

  // stage 3: add month offset, leap day and day of month
  logic            lday3;
  logic [CntW-1:0] num3;
  logic [CntW-1:0] num3_r;
  logic            ok3_r;

  assign lday3 = leap2_r && (m2_r > MonW'(2));
  assign num3  = yb2_r + CntW'(days_before(m2_r)) + CntW'(lday3) + CntW'(d2_r);

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      num3_r <= num3;
      ok3_r  <= ok2_r;
    end
  end

  assign day_num = num3_r;
  assign date_ok = ok3_r;

endmodule

`default_nettype wire

FILE: hw/rtl/days_between_dates_unit.sv
// throughput: one word per cycle while out_tready is high; four register stages, each with its own valid bit
// stalls ripple back stage by stage, so empty stages keep taking words
// reset (rst_n low, synchronous) clears the valid bits only; no other state
`timescale 1ns / 1ps
`default_nettype none

`include "days_between_dates_unit_assert.svh"

module days_between_dates_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // start_day[4:0], start_month[8:5], start_year[22:9],
  // end_day[27:23], end_month[31:28], end_year[45:32], zero fill [47:46]
  input  wire logic [47:0] in_tdata,
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // day_count[21:0], zero fill [23:22]
  output logic [23:0]      out_tdata,
  // status[1:0]
  output logic [1:0]       out_tuser
);
  import dbd_pkg::*;

  pipe_ctl_t ctl;

  // valid bits and per-stage enables
  dbd_pipe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  // unpack the input word
  logic [DayW-1:0]  start_day;
  logic [MonW-1:0]  start_month;
  logic [YearW-1:0] start_year;
  logic [DayW-1:0]  end_day;
  logic [MonW-1:0]  end_month;
  logic [YearW-1:0] end_year;

  assign start_day   = in_tdata[4:0];
  assign start_month = in_tdata[8:5];
  assign start_year  = in_tdata[22:9];
  assign end_day     = in_tdata[27:23];
  assign end_month   = in_tdata[31:28];
  assign end_year    = in_tdata[45:32];

  // stages 1..3: both dates to day numbers in parallel
  logic [CntW-1:0] start_num;
  logic [CntW-1:0] end_num;
  logic            start_ok;
  logic            end_ok;

  dbd_date_conv u_start (
    .clk     (clk),
    .ctl     (ctl),
    .day     (start_day),
    .month   (start_month),
    .year    (start_year),
    .day_num (start_num),
    .date_ok (start_ok)
  );

  dbd_date_conv u_end (
    .clk     (clk),
    .ctl     (ctl),
    .day     (end_day),
    .month   (end_month),
    .year    (end_year),
    .day_num (end_num),
    .date_ok (end_ok)
  );

  // stage 4: subtract and classify into the output register
  // invalid date wins over wrong order; any fault zeroes the count
  logic [CntW-1:0] diff;
  logic [CntW-1:0] count_nxt;
  status_t         status_nxt;
  logic [CntW-1:0] count_r;
  status_t         status_r;

  assign diff = end_num - start_num;

  always_comb begin
    count_nxt  = '0;
    status_nxt = STAT_OK;
    if (!start_ok || !end_ok) begin
      status_nxt = STAT_INVALID;
    end else if (end_num < start_num) begin
      status_nxt = STAT_ORDER;
    end else begin
      count_nxt = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[NumStages-1]) begin
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = ctl.vld[NumStages-1];
  assign out_tdata  = {2'b00, count_r};
  assign out_tuser  = status_r;

  // a faulted word never carries a count
  `DBD_ASSERT_IMPL(a_fault_zero, clk, rst_n,
                   out_tvalid && (status_r != STAT_OK), count_r == '0,
                   "nonzero count with fault status")
  // a full last stage that is not taken keeps its word
  `DBD_ASSERT_NEXT(a_hold_last, clk, rst_n,
                   out_tvalid && !out_tready, out_tvalid,
                   "result dropped under stall")
  // a blocked stage keeps its valid bit, so stalls lose nothing inside
  `DBD_ASSERT_NEXT(a_hold_inner, clk, rst_n,
                   ctl.vld[0] && !ctl.en[1], ctl.vld[0],
                   "first stage lost a word under stall")
  // input ready follows the first stage's state
  `DBD_ASSERT_IMPL(a_ready_free, clk, rst_n,
                   !ctl.vld[0], in_tready,
                   "input stalled with empty first stage")

endmodule

`default_nettype wire
